FILE: rtl/bitmap_first_free_allocator_core_assert.svh
// Assertion macros used by the allocator request sequencer
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTH
`define BFA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFA_ASSERT(lbl, prop, msg)
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/bfa_pkg.sv
// Types, constants and sizes shared by the allocator modules
package bfa_pkg;

    localparam int MAX_CLUSTERS = 4096;
    localparam int MAP_DEPTH    = MAX_CLUSTERS / 8;
    localparam int WORD_W       = (MAX_CLUSTERS < 64) ? MAX_CLUSTERS : 64;
    localparam int N_WORDS      = MAX_CLUSTERS / WORD_W;
    localparam int WB           = $clog2(WORD_W);
    localparam int WA           = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
    localparam int BPW          = WORD_W / 8;
    localparam int KB           = (BPW > 1) ? $clog2(BPW) : 1;
    localparam int IDX_W        = $clog2(MAX_CLUSTERS);
    localparam int LIM_W        = $clog2(MAX_CLUSTERS + 1);
    localparam int VB_W         = $clog2(MAP_DEPTH + 1);

    localparam int REQ_W     = 2;
    localparam int CIDX_W    = 12;
    localparam int BIDX_W    = 9;
    localparam int BYTE_W    = 8;
    localparam int STAT_W    = 2;
    localparam int CC_W      = 13;
    localparam int MB_W      = 10;
    localparam int CFG_W     = 13;
    localparam int CFG_A_W   = 1;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [CC_W-1:0] CC_RST = CC_W'(4096);
    localparam logic [MB_W-1:0] MB_RST = MB_W'(512);

    localparam logic [CFG_A_W-1:0] CFG_CLUSTER_COUNT = 1'b0;
    localparam logic [CFG_A_W-1:0] CFG_MAP_BYTES     = 1'b1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_LOAD  = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_RD,
        S_CHK,
        S_REPLY
    } t_state;

    typedef struct packed {
        logic capture;
        logic rd;
        logic adv;
        logic finish;
        logic err;
        logic push;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic err;
        logic hit;
        logic last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/bfa_ram.sv
// Generic single-port-write RAM with registered read
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bfa_ctrl.sv
// Request sequencer for the allocator
`include "bitmap_first_free_allocator_core_assert.svh"

module bfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  bfa_pkg::t_sts i_sts,
    output bfa_pkg::t_cmd o_cmd
);
    import bfa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_START;
            end
            S_START: begin
                n_state = i_sts.err ? S_REPLY : S_CHK;
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (i_sts.req == REQ_ALLOC && !i_sts.hit && !i_sts.last) n_state = S_RD;
                else n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.capture = i_s_tvalid;
            end
            S_START: begin
                o_cmd.err = i_sts.err;
                o_cmd.rd  = !i_sts.err;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
            end
            S_CHK: begin
                if (i_sts.req == REQ_ALLOC && !i_sts.hit && !i_sts.last) o_cmd.adv = 1'b1;
                else o_cmd.finish = 1'b1;
            end
            S_REPLY: begin
                o_cmd.push = i_sts.out_free;
            end
            default: ;
        endcase
    end

    `BFA_ASSERT(a_cmd_onehot, $onehot0(o_cmd), "more than one datapath command")
    `BFA_ASSERT(a_chk_after_rd, (r_state == S_CHK) |-> $past(o_cmd.rd), "word checked without a read")
    `BFA_ASSERT_NEXT(a_accept_start, i_s_tvalid && o_s_tready, r_state == S_START, "accepted beat not started")

endmodule

FILE: rtl/bfa_dp.sv
// Datapath: configuration, free map store, word search and result registers
module bfa_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [bfa_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [bfa_pkg::CFG_W-1:0]     i_cfg_wdata,
    // cluster_index, byte_index, load_byte from bit 0 up
    input  logic [bfa_pkg::S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  logic [bfa_pkg::REQ_W-1:0]     i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // granted_index, is_allocated from bit 0 up
    output logic [bfa_pkg::M_TDATA_W-1:0] o_m_tdata,
    // status
    output logic [bfa_pkg::STAT_W-1:0]    o_m_tuser,
    input  bfa_pkg::t_cmd                 i_cmd,
    output bfa_pkg::t_sts                 o_sts
);
    import bfa_pkg::*;

    logic [CC_W-1:0]   r_cluster_count;
    logic [MB_W-1:0]   r_map_bytes;

    logic [CIDX_W-1:0] in_cidx;
    logic [BIDX_W-1:0] in_bidx;
    logic [BYTE_W-1:0] in_lbyte;
    t_req              in_req;
    logic [VB_W-1:0]   vb;
    logic [LIM_W-1:0]  cc_cap;
    logic [LIM_W-1:0]  vb_bits;
    logic [LIM_W-1:0]  limit;
    logic              in_err;
    logic [WA-1:0]     in_word;

    t_req              r_req;
    logic [WB-1:0]     r_cidx_bit;
    logic [KB-1:0]     r_byte_sel;
    logic [BYTE_W-1:0] r_lbyte;
    logic [LIM_W-1:0]  r_limit;
    logic              r_err;
    logic [WA-1:0]     r_word;
    logic [N_WORDS-1:0] r_vld;
    logic              r_rd_vld;

    logic [WORD_W-1:0] ram_q;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_we;

    logic [LIM_W-1:0]  base;
    logic [LIM_W-1:0]  next_base;
    logic [LIM_W-1:0]  rem;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] masked;
    logic [WORD_W-1:0] onehot;
    logic [WB-1:0]     hit_idx;
    logic              hit;
    logic              cur_bit;
    logic [WORD_W-1:0] bitmask;
    logic [WORD_W-1:0] merged;

    t_status           res_status;
    logic [IDX_W-1:0]  res_granted;
    logic              res_alloc;
    t_status           r_res_status;
    logic [IDX_W-1:0]  r_res_granted;
    logic              r_res_alloc;

    logic              r_out_vld;
    t_status           r_out_status;
    logic [IDX_W-1:0]  r_out_granted;
    logic              r_out_alloc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cluster_count <= CC_RST;
            r_map_bytes     <= MB_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_CLUSTER_COUNT: r_cluster_count <= i_cfg_wdata[CC_W-1:0];
                CFG_MAP_BYTES:     r_map_bytes     <= i_cfg_wdata[MB_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_cidx  = i_s_tdata[CIDX_W-1:0];
    assign in_bidx  = i_s_tdata[CIDX_W +: BIDX_W];
    assign in_lbyte = i_s_tdata[CIDX_W+BIDX_W +: BYTE_W];
    assign in_req   = t_req'(i_s_tuser);

    assign vb      = (32'(r_map_bytes) > 32'(MAP_DEPTH)) ? VB_W'(MAP_DEPTH) : VB_W'(r_map_bytes);
    assign cc_cap  = (32'(r_cluster_count) > 32'(MAX_CLUSTERS)) ? LIM_W'(MAX_CLUSTERS)
                                                                : LIM_W'(r_cluster_count);
    assign vb_bits = LIM_W'(vb) << 3;
    assign limit   = (cc_cap < vb_bits) ? cc_cap : vb_bits;

    always_comb begin
        in_err  = 1'b0;
        in_word = '0;
        case (in_req) inside
            REQ_ALLOC: begin
                in_err = (limit == '0);
            end
            REQ_FREE, REQ_QUERY: begin
                in_err  = (32'(in_cidx >> 3) >= 32'(vb));
                in_word = WA'(in_cidx >> WB);
            end
            default: begin
                in_err  = (32'(in_bidx) >= 32'(MAP_DEPTH));
                in_word = WA'(in_bidx >> KB);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req      <= in_req;
            r_cidx_bit <= in_cidx[WB-1:0];
            r_byte_sel <= in_bidx[KB-1:0];
            r_lbyte    <= in_lbyte;
            r_limit    <= limit;
            r_err      <= in_err;
            r_word     <= in_word;
        end else if (i_cmd.adv) begin
            r_word <= r_word + WA'(1);
        end
        if (i_cmd.rd) begin
            r_rd_vld <= r_vld[r_word];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ram_we) begin
            r_vld[r_word] <= 1'b1;
        end
    end

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (N_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_word),
        .o_rdata (ram_q)
    );

    assign word = r_rd_vld ? ram_q : '1;

    assign base      = LIM_W'({r_word, {WB{1'b0}}});
    assign next_base = base + LIM_W'(WORD_W);
    assign rem       = r_limit - base;
    assign mask      = (rem >= LIM_W'(WORD_W)) ? '1
                                               : ((WORD_W'(1) << rem[WB-1:0]) - WORD_W'(1));
    assign masked    = word & mask;
    assign hit       = |masked;
    assign onehot    = masked & (~masked + WORD_W'(1));

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (onehot[i]) hit_idx = hit_idx | WB'(i);
        end
    end

    assign cur_bit = word[r_cidx_bit];
    assign bitmask = WORD_W'(1) << r_cidx_bit;

    always_comb begin
        merged = word;
        for (int i = 0; i < BYTE_W; i++) begin
            merged[{r_byte_sel, 3'(i)}] = r_lbyte[BYTE_W-1-i];
        end
    end

    always_comb begin
        res_status  = ST_OK;
        res_granted = '0;
        res_alloc   = 1'b0;
        ram_wdata   = word;
        ram_we      = 1'b0;
        if (i_cmd.err) begin
            res_status = (r_req == REQ_ALLOC) ? ST_NONE_FREE : ST_RANGE;
        end else begin
            case (r_req)
                REQ_ALLOC: begin
                    if (hit) begin
                        res_granted = {r_word, hit_idx};
                        ram_wdata   = word & ~onehot;
                        ram_we      = i_cmd.finish;
                    end else begin
                        res_status = ST_NONE_FREE;
                    end
                end
                REQ_FREE: begin
                    if (cur_bit) begin
                        res_status = ST_NOT_ALLOC;
                    end else begin
                        ram_wdata = word | bitmask;
                        ram_we    = i_cmd.finish;
                    end
                end
                REQ_QUERY: begin
                    res_alloc = ~cur_bit;
                end
                default: begin
                    ram_wdata = merged;
                    ram_we    = i_cmd.finish;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish || i_cmd.err) begin
            r_res_status  <= res_status;
            r_res_granted <= res_granted;
            r_res_alloc   <= res_alloc;
        end
        if (i_cmd.push) begin
            r_out_status  <= r_res_status;
            r_out_granted <= r_res_granted;
            r_out_alloc   <= r_res_alloc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = M_TDATA_W'({r_out_alloc, r_out_granted});
    assign o_m_tuser  = r_out_status;

    assign o_sts.req      = r_req;
    assign o_sts.err      = r_err;
    assign o_sts.hit      = hit;
    assign o_sts.last     = (next_base >= r_limit);
    assign o_sts.out_free = !r_out_vld || i_m_tready;

endmodule

FILE: rtl/bitmap_first_free_allocator_core.sv
// Top level of the first-fit bitmap cluster allocator
// A range or empty-limit error replies without a map read; free, query and load read and
// check one map word; allocate scans 64-bit map words from word 0 to a hit or the limit.
// One request in flight; the next beat can be taken once the result is offered on m_axis.
// Allocate time is set by the word scan: one RAM read and one check per map word.
// Synchronous active-low reset: map reads all free through per-word valid bits, no clearing
// pass; cluster_count resets to 4096 and map_bytes to 512.
module bitmap_first_free_allocator_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic [bfa_pkg::CFG_A_W-1:0]   i_cfg_addr,
    input  logic [bfa_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cluster_index [11:0], byte_index [20:12], load_byte [28:21]
    input  logic [bfa_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // req_type [1:0]
    input  logic [bfa_pkg::REQ_W-1:0]     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // granted_index [11:0], is_allocated [12]
    output logic [bfa_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status [1:0]
    output logic [bfa_pkg::STAT_W-1:0]    m_axis_tuser
);
    import bfa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule
